@@ rtl/sfr_pkg.sv @@
// sfr_pkg: constants and shared types of the serial frame receiver.
// Used by every module and interface under rtl/ except sfr_ram; depends on nothing.
`default_nettype none

package sfr_pkg;

   localparam int BYTE_W            = 8;
   localparam int INDEX_W           = 5;
   localparam int MAX_FRAME_DEFAULT = 30;

   localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'h5A;
   localparam logic [BYTE_W-1:0] HDR_SECOND = 8'hA5;
   localparam logic [BYTE_W-1:0] STOP_B3    = 8'h83;
   localparam logic [BYTE_W-1:0] STOP_B4    = 8'h60;
   localparam logic [BYTE_W-1:0] STOP_B5    = 8'h00;

   // controller -> datapath
   typedef struct packed {
      logic accept;      // store incoming byte
      logic restart;     // drop frame in progress, count back to zero
      logic emit_start;  // latch frame end info, index to zero
      logic rd_en;       // read store at emit index
      logic advance;     // step emit index
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic hdr_bad;     // header byte mismatch
      logic done;        // incoming byte completes the frame
      logic full;        // incoming byte fills the store
      logic last;        // emit index sits on the final byte
   } status_type;

endpackage

`default_nettype wire

@@ rtl/sfr_if.sv @@
// sfr_if: handshake interfaces for the byte input and the frame word output.
// Depends on sfr_pkg for field widths.
`default_nettype none

interface sfr_rx_if;
   logic                        valid;
   logic                        ready;
   logic [sfr_pkg::BYTE_W-1:0]  rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfr_frame_if;
   logic                        valid;
   logic                        ready;
   logic [sfr_pkg::BYTE_W-1:0]  frame_byte;
   logic [sfr_pkg::INDEX_W-1:0] byte_index;
   logic                        last_byte;
   logic                        is_stop;

   modport source (output valid, output frame_byte, output byte_index,
                   output last_byte, output is_stop, input ready);
   modport sink   (input valid, input frame_byte, input byte_index,
                   input last_byte, input is_stop, output ready);
endinterface

`default_nettype wire

@@ rtl/sfr_ram.sv @@
// sfr_ram: generic single-port-write, single-port-read RAM, registered read.
// No dependencies.
`default_nettype none

module sfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 30,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/sfr_datapath.sv @@
// sfr_datapath: byte count, length and stop tracking, frame store, emit index.
// Depends on sfr_pkg and sfr_ram.
`default_nettype none

module sfr_datapath #(
   parameter int MAX_FRAME = sfr_pkg::MAX_FRAME_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire sfr_pkg::cmd_type             cmd,
   output sfr_pkg::status_type               status,
   input  wire logic [sfr_pkg::BYTE_W-1:0]   rx_byte,
   output logic      [sfr_pkg::BYTE_W-1:0]   frame_byte,
   output logic      [sfr_pkg::INDEX_W-1:0]  byte_index,
   output logic                              last_byte,
   output logic                              is_stop
);

   localparam int IDX_W   = $clog2(MAX_FRAME);
   localparam int COUNT_W = $clog2(MAX_FRAME + 1);

   logic [IDX_W-1:0]          count_ff, count_in;
   logic [sfr_pkg::BYTE_W-1:0] len_ff, len_in;
   logic                       stop_ff, stop_in;
   logic                       frame_stop_ff, frame_stop_in;
   logic [IDX_W-1:0]           last_idx_ff, last_idx_in;
   logic [IDX_W-1:0]           idx_ff, idx_in;

   logic [sfr_pkg::BYTE_W-1:0] len_cur;
   logic                       stop_next;

   // the length byte is live on the input when it arrives
   assign len_cur = (count_ff == IDX_W'(2)) ? rx_byte : len_ff;

   always_comb begin
      status.hdr_bad = ((count_ff == IDX_W'(0)) && (rx_byte != sfr_pkg::HDR_FIRST)) ||
                       ((count_ff == IDX_W'(1)) && (rx_byte != sfr_pkg::HDR_SECOND));
      status.done    = (count_ff >= IDX_W'(2)) &&
                       (8'(count_ff - IDX_W'(2)) == len_cur);
      status.full    = (count_ff == IDX_W'(MAX_FRAME - 1));
      status.last    = (idx_ff == last_idx_ff);
   end

   always_comb begin
      if (count_ff < IDX_W'(3)) begin
         stop_next = 1'b0;
      end else if (count_ff == IDX_W'(3)) begin
         stop_next = (rx_byte == sfr_pkg::STOP_B3);
      end else if (count_ff == IDX_W'(4)) begin
         stop_next = stop_ff && (rx_byte == sfr_pkg::STOP_B4);
      end else if (count_ff == IDX_W'(5)) begin
         stop_next = stop_ff && (rx_byte == sfr_pkg::STOP_B5);
      end else begin
         stop_next = stop_ff;
      end
   end

   always_comb begin
      count_in      = count_ff;
      len_in        = len_ff;
      stop_in       = stop_ff;
      frame_stop_in = frame_stop_ff;
      last_idx_in   = last_idx_ff;
      idx_in        = idx_ff;
      if (cmd.accept) begin
         len_in  = len_cur;
         stop_in = stop_next;
         if (cmd.restart) begin
            count_in = '0;
         end else begin
            count_in = count_ff + IDX_W'(1);
         end
      end
      if (cmd.emit_start) begin
         // stop tag needs bytes 3..5 inside the frame
         frame_stop_in = stop_next && (count_ff >= IDX_W'(5));
         last_idx_in   = count_ff;
         idx_in        = '0;
      end
      if (cmd.advance) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         stop_ff  <= 1'b0;
         idx_ff   <= '0;
      end else begin
         count_ff <= count_in;
         stop_ff  <= stop_in;
         idx_ff   <= idx_in;
      end
      len_ff        <= len_in;
      frame_stop_ff <= frame_stop_in;
      last_idx_ff   <= last_idx_in;
   end

   sfr_ram #(
      .WIDTH (sfr_pkg::BYTE_W),
      .DEPTH (MAX_FRAME),
      .AW    (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.accept),
      .wr_addr (count_ff),
      .wr_data (rx_byte),
      .rd_en   (cmd.rd_en),
      .rd_addr (idx_ff),
      .rd_data (frame_byte)
   );

   assign byte_index = sfr_pkg::INDEX_W'(idx_ff);
   assign last_byte  = status.last;
   assign is_stop    = frame_stop_ff;

   ap_count_in_range : assert property (@(posedge clock) disable iff (reset)
      COUNT_W'(count_ff) < COUNT_W'(MAX_FRAME))
      else $error("byte count beyond store depth");

   ap_idx_in_frame : assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |-> (idx_ff <= last_idx_ff))
      else $error("emit index past end of frame");

endmodule

`default_nettype wire

@@ rtl/sfr_ctrl.sv @@
// sfr_ctrl: receive / emit sequencer of the serial frame receiver.
// Depends on sfr_pkg; drives the datapath through cmd_type, reads status_type.
`default_nettype none

module sfr_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output sfr_pkg::cmd_type         cmd,
   input  wire sfr_pkg::status_type status
);

   typedef enum logic [1:0] {
      S_RECV,
      S_READ,
      S_SHOW
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      req_fire;
   logic      rsp_fire;

   assign req_ready = (state_ff == S_RECV);
   assign rsp_valid = rsp_valid_ff;
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;

   always_comb begin
      cmd.accept     = req_fire;
      cmd.restart    = req_fire && (status.hdr_bad || status.done || status.full);
      cmd.emit_start = req_fire && status.done;
      cmd.rd_en      = (state_ff == S_READ);
      cmd.advance    = rsp_fire && !status.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_RECV;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_RECV: begin
               if (req_fire && status.done) begin
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               state_ff     <= S_SHOW;
               rsp_valid_ff <= 1'b1;
            end
            S_SHOW: begin
               if (rsp_fire) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= status.last ? S_RECV : S_READ;
               end
            end
            default: begin
               state_ff     <= S_RECV;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

   ap_no_overlap : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req_ready)
      else $error("input taken while a word is pending");

   ap_emit_needs_done : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RECV) && req_fire && status.done |=> rsp_valid_ff == 1'b0 &&
      state_ff == S_READ)
      else $error("frame end did not start emit");

   ap_last_releases : assert property (@(posedge clock) disable iff (reset)
      rsp_fire && status.last |=> req_ready)
      else $error("receiver not reopened after last word");

endmodule

`default_nettype wire

@@ rtl/serial_frame_receiver.sv @@
// serial_frame_receiver: top level, joins sequencer and datapath to the channels.
// Depends on sfr_pkg, sfr_if, sfr_ctrl, sfr_datapath (and sfr_ram below it).
//
// Usage:
//   req_chan takes one received serial byte per word. Frames start with 0x5A,
//   0xA5; the third byte L gives the bytes that follow, so a frame is L + 3
//   bytes. Bad header bytes restart the search; a frame longer than MAX_FRAME
//   is dropped with no output.
//   rsp_chan gives one word per frame byte once the frame is complete:
//   the byte, its index, a last flag on the final byte and a stop tag
//   (bytes 3..5 equal 0x83 0x60 0x00) repeated on every word of the frame.
//   A completing byte starts the emit, during which req_chan.ready is low;
//   each output word is a store read, then the word shown, held for as long
//   as rsp_chan.ready stays low, so the input stays blocked until the last
//   word of the frame is taken. The frame store has a single read port.
//   A stalled output word holds its value until taken.
//   Reset clears the byte count and the sequencer; store contents are not
//   cleared, only bytes of the current frame are ever read.
`default_nettype none

module serial_frame_receiver #(
   parameter int MAX_FRAME = sfr_pkg::MAX_FRAME_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   sfr_rx_if.sink     req_chan,
   sfr_frame_if.source rsp_chan
);

   sfr_pkg::cmd_type    cmd;
   sfr_pkg::status_type status;

   sfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   sfr_datapath #(
      .MAX_FRAME (MAX_FRAME)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .rx_byte    (req_chan.rx_byte),
      .frame_byte (rsp_chan.frame_byte),
      .byte_index (rsp_chan.byte_index),
      .last_byte  (rsp_chan.last_byte),
      .is_stop    (rsp_chan.is_stop)
   );

endmodule

`default_nettype wire
